[rtl/vector_set_length_macros.svh]
// assertion macros for the vector_set_length block
// expects clk and rst_n in the scope where a macro is used
`ifndef VECTOR_SET_LENGTH_MACROS_SVH
`define VECTOR_SET_LENGTH_MACROS_SVH

// condition holds in the same cycle
`define VSL_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// condition holds in the cycle after the antecedent
`define VSL_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

[rtl/vsl_pkg.sv]
// shared types and constants for the vector_set_length block
// no dependencies
package vsl_pkg;

    localparam int COMP_W  = 24;
    localparam int TGT_W   = COMP_W - 1;
    localparam int MAG_W   = COMP_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int PROD_W  = MAG_W + TGT_W;
    localparam int Q_W     = TGT_W;
    localparam int LANES   = 3;

    typedef struct packed {
        logic signed [COMP_W-1:0] vec_x;
        logic signed [COMP_W-1:0] vec_y;
        logic signed [COMP_W-1:0] vec_z;
        logic [TGT_W-1:0]         target_length;
    } item_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] scaled_x;
        logic signed [COMP_W-1:0] scaled_y;
        logic signed [COMP_W-1:0] scaled_z;
        logic [COMP_W-1:0]        input_length;
        logic                     zero_vector;
    } result_t;

    typedef struct packed {
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [LANES-1:0]            neg;
        logic [TGT_W-1:0]            target;
    } side_t;

    typedef struct packed {
        logic [ROOT_W-1:0] len;
        logic              zero;
    } len_info_t;

endpackage

[rtl/vsl_square.sv]
// one lane front end: magnitude and square of a signed component
// depends on vsl_pkg
module vsl_square (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [vsl_pkg::COMP_W-1:0] comp,
    output logic [vsl_pkg::MAG_W-1:0]         mag,
    output logic                              neg,
    output logic [vsl_pkg::SQ_W-1:0]          sq
);

    logic [vsl_pkg::MAG_W-1:0] mag_next;
    logic [vsl_pkg::MAG_W-1:0] mag_reg;
    logic                      neg_reg;
    logic [vsl_pkg::SQ_W-1:0]  sq_reg;

    always_comb
    begin
        if (comp[vsl_pkg::COMP_W-1])
        begin
            mag_next = ~vsl_pkg::MAG_W'(comp) + vsl_pkg::MAG_W'(1);
        end
        else
        begin
            mag_next = vsl_pkg::MAG_W'(comp);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            neg_reg <= comp[vsl_pkg::COMP_W-1];
            sq_reg  <= vsl_pkg::SQ_W'(mag_next) * vsl_pkg::SQ_W'(mag_next);
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;
    assign sq  = sq_reg;

endmodule

[rtl/vsl_sqrt.sv]
// pipelined integer square root, one root bit per stage
// depends on vsl_pkg
module vsl_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [vsl_pkg::SQ_W-1:0]    radicand,
    input  vsl_pkg::side_t              side_in,
    output logic [vsl_pkg::ROOT_W-1:0]  root,
    output vsl_pkg::side_t              side_out
);

    localparam int N = vsl_pkg::ROOT_W;

    logic [vsl_pkg::SQ_W-1:0] rem_reg  [N];
    logic [vsl_pkg::SQ_W-1:0] root_reg [N];
    vsl_pkg::side_t           side_reg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic [vsl_pkg::SQ_W-1:0] rem_in;
            logic [vsl_pkg::SQ_W-1:0] root_in;
            vsl_pkg::side_t           side_i;
            logic [vsl_pkg::SQ_W-1:0] bit_w;
            logic [vsl_pkg::SQ_W-1:0] trial;
            logic [vsl_pkg::SQ_W-1:0] rem_next;
            logic [vsl_pkg::SQ_W-1:0] root_next;

            if (k == 0)
            begin : g_first
                assign rem_in  = radicand;
                assign root_in = '0;
                assign side_i  = side_in;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign side_i  = side_reg[k-1];
            end

            assign bit_w = vsl_pkg::SQ_W'(1) << (2 * (N - 1 - k));
            assign trial = root_in + bit_w;

            always_comb
            begin
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = (root_in >> 1) + bit_w;
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    side_reg[k] <= side_i;
                end
            end
        end
    endgenerate

    assign root     = root_reg[N-1][N-1:0];
    assign side_out = side_reg[N-1];

endmodule

[rtl/vsl_div.sv]
// one lane back end: product with target, pipelined restoring divide, sign
// depends on vsl_pkg
module vsl_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic [vsl_pkg::MAG_W-1:0]         mag,
    input  logic                              neg,
    input  logic [vsl_pkg::TGT_W-1:0]         target,
    input  logic [vsl_pkg::ROOT_W-1:0]        len,
    output logic signed [vsl_pkg::COMP_W-1:0] scaled
);

    localparam int N = vsl_pkg::Q_W;

    logic [vsl_pkg::PROD_W-1:0] prod_reg;
    logic                       neg0_reg;
    logic [vsl_pkg::ROOT_W-1:0] len0_reg;

    logic [vsl_pkg::PROD_W-1:0] rem_reg [N];
    logic [N-1:0]               q_reg   [N];
    logic                       neg_reg [N];
    logic [vsl_pkg::ROOT_W-1:0] len_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= vsl_pkg::PROD_W'(mag) * vsl_pkg::PROD_W'(target);
            neg0_reg <= neg;
            len0_reg <= len;
        end
    end

    genvar j;
    generate
        for (j = 0; j < N; j++)
        begin : g_stage
            logic [vsl_pkg::PROD_W-1:0] rem_in;
            logic [N-1:0]               q_in;
            logic                       neg_in;
            logic [vsl_pkg::ROOT_W-1:0] len_in;
            logic [vsl_pkg::PROD_W:0]   trial;
            logic [vsl_pkg::PROD_W-1:0] rem_next;
            logic [N-1:0]               q_next;

            if (j == 0)
            begin : g_first
                assign rem_in = prod_reg;
                assign q_in   = '0;
                assign neg_in = neg0_reg;
                assign len_in = len0_reg;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign q_in   = q_reg[j-1];
                assign neg_in = neg_reg[j-1];
                assign len_in = len_reg[j-1];
            end

            assign trial = (vsl_pkg::PROD_W+1)'(len_in) << (N - 1 - j);

            always_comb
            begin
                rem_next = rem_in;
                q_next   = q_in;
                if ({1'b0, rem_in} >= trial)
                begin
                    rem_next          = rem_in - trial[vsl_pkg::PROD_W-1:0];
                    q_next[N - 1 - j] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_next;
                    q_reg[j]   <= q_next;
                    neg_reg[j] <= neg_in;
                    len_reg[j] <= len_in;
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (neg_reg[N-1])
        begin
            scaled = ~vsl_pkg::COMP_W'(q_reg[N-1]) + vsl_pkg::COMP_W'(1);
        end
        else
        begin
            scaled = vsl_pkg::COMP_W'(q_reg[N-1]);
        end
    end

endmodule

[rtl/vector_set_length.sv]
// throughput: one transaction per cycle; the whole pipeline advances when the output
// register is empty or being taken, and the root and divide stages are one bit each
// reset: rst_n asynchronous active low clears the valid pipe and the output valid
// top level of vector_set_length: square lanes, root pipeline, divide lanes, merge
// depends on vsl_pkg, vsl_square, vsl_sqrt, vsl_div, vector_set_length_macros.svh
`include "vector_set_length_macros.svh"
module vector_set_length (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  vsl_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output vsl_pkg::result_t result
);

    localparam int DIV_LAT = vsl_pkg::Q_W + 1;
    localparam int PIPE    = 2 + vsl_pkg::ROOT_W + DIV_LAT;

    logic adv;
    logic [PIPE-1:0] vld_reg;
    logic            out_valid_reg;
    vsl_pkg::result_t out_reg;
    vsl_pkg::result_t out_next;

    logic signed [vsl_pkg::LANES-1:0][vsl_pkg::COMP_W-1:0] comp;
    logic [vsl_pkg::LANES-1:0][vsl_pkg::MAG_W-1:0] mag;
    logic [vsl_pkg::LANES-1:0]                     neg;
    logic [vsl_pkg::LANES-1:0][vsl_pkg::SQ_W-1:0]  sq;
    logic [vsl_pkg::LANES-1:0][vsl_pkg::COMP_W-1:0] scaled;

    logic [vsl_pkg::TGT_W-1:0] tgt_reg;
    logic [vsl_pkg::SQ_W-1:0]  sum_reg;
    vsl_pkg::side_t            side_reg;
    vsl_pkg::side_t            side_root;
    logic [vsl_pkg::ROOT_W-1:0] root;
    vsl_pkg::len_info_t        len_dly_reg [DIV_LAT];

    logic in_take;
    logic out_blocked;
    logic zero_seen;
    logic len_seen;
    logic out_all_zero;

    assign adv        = !out_valid_reg || !result_stall;
    assign item_stall = !adv;

    assign comp[0] = item.vec_x;
    assign comp[1] = item.vec_y;
    assign comp[2] = item.vec_z;

    genvar l;
    generate
        for (l = 0; l < vsl_pkg::LANES; l++)
        begin : g_sq
            vsl_square u_square (
                .clk  (clk),
                .en   (adv),
                .comp (comp[l]),
                .mag  (mag[l]),
                .neg  (neg[l]),
                .sq   (sq[l])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tgt_reg         <= item.target_length;
            sum_reg         <= sq[0] + sq[1] + sq[2];
            side_reg.mag    <= mag;
            side_reg.neg    <= neg;
            side_reg.target <= tgt_reg;
        end
    end

    vsl_sqrt u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (sum_reg),
        .side_in  (side_reg),
        .root     (root),
        .side_out (side_root)
    );

    generate
        for (l = 0; l < vsl_pkg::LANES; l++)
        begin : g_div
            vsl_div u_div (
                .clk    (clk),
                .en     (adv),
                .mag    (side_root.mag[l]),
                .neg    (side_root.neg[l]),
                .target (side_root.target),
                .len    (root),
                .scaled (scaled[l])
            );
        end
    endgenerate

    genvar d;
    generate
        for (d = 0; d < DIV_LAT; d++)
        begin : g_len
            if (d == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        len_dly_reg[d].len  <= root;
                        len_dly_reg[d].zero <= (root == '0);
                    end
                end
            end
            else
            begin : g_rest
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        len_dly_reg[d] <= len_dly_reg[d-1];
                    end
                end
            end
        end
    endgenerate

    // merge lanes, zero vector forces scaled outputs and length to zero and sets zero_vector
    always_comb
    begin
        if (len_dly_reg[DIV_LAT-1].zero)
        begin
            out_next              = '0;
            out_next.zero_vector  = 1'b1;
        end
        else
        begin
            out_next.scaled_x     = scaled[0];
            out_next.scaled_y     = scaled[1];
            out_next.scaled_z     = scaled[2];
            out_next.input_length = len_dly_reg[DIV_LAT-1].len;
            out_next.zero_vector  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[PIPE-2:0], item_valid};
            out_valid_reg <= vld_reg[PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign in_take      = item_valid && !item_stall;
    assign out_blocked  = result_valid && result_stall;
    assign zero_seen    = result_valid && result.zero_vector;
    assign len_seen     = result_valid && !result.zero_vector;
    assign out_all_zero = result.scaled_x == '0 && result.scaled_y == '0
                          && result.scaled_z == '0 && result.input_length == '0;

    `VSL_ASSERT_NOW(a_stall_only_when_blocked, item_stall, out_blocked, "stall while output free")
    `VSL_ASSERT_NOW(a_zero_clears_outputs, zero_seen, out_all_zero, "nonzero outputs on zero vector")
    `VSL_ASSERT_NOW(a_length_nonzero, len_seen, result.input_length != '0, "zero length without flag")
    `VSL_ASSERT_NEXT(a_pipe_fills, in_take, vld_reg[0], "accepted transaction lost at entry")

endmodule
